// ===== design/bmt_pkg.sv =====
// Package for the breakpoint match table: request and response structs,
// kind, type, mode and status codes. No dependencies.
package bmt_pkg;

   localparam logic [2:0] KIND_CHECK  = 3'd0;
   localparam logic [2:0] KIND_ADD    = 3'd1;
   localparam logic [2:0] KIND_REMOVE = 3'd2;
   localparam logic [2:0] KIND_CLEAR  = 3'd3;
   localparam logic [2:0] KIND_IGNORE = 3'd4;
   localparam logic [2:0] KIND_ALL    = 3'd5;
   localparam logic [2:0] KIND_RUN    = 3'd6;
   localparam logic [2:0] KIND_STEP   = 3'd7;

   localparam logic [2:0] TYPE_EXEC       = 3'd0;
   localparam logic [2:0] TYPE_READ       = 3'd1;
   localparam logic [2:0] TYPE_WRITE      = 3'd2;
   localparam logic [2:0] TYPE_PORT_READ  = 3'd3;
   localparam logic [2:0] TYPE_PORT_WRITE = 3'd4;
   localparam logic [2:0] TYPE_TIME       = 3'd5;
   localparam logic [2:0] TYPE_RSVD6      = 3'd6;
   localparam logic [2:0] TYPE_RSVD7      = 3'd7;

   localparam logic [1:0] MODE_INACTIVE = 2'd0;
   localparam logic [1:0] MODE_ACTIVE   = 2'd1;
   localparam logic [1:0] MODE_HALTED   = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_MISSING = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   localparam logic [31:0] OFFSET_MASK = 32'h0000_3fff;

   typedef struct packed {
      logic [2:0]  kind;
      logic [2:0]  access_type;
      logic [31:0] value;
      logic [7:0]  mapped_page;
      logic [31:0] cycle_count;
      logic        page_given;
      logic [7:0]  page_number;
      logic [15:0] ignore_count;
      logic        oneshot;
      logic [15:0] entry_id;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [1:0]  status;
      logic [15:0] new_id;
      logic [1:0]  mode_now;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  btype;
      logic        paged;
      logic [7:0]  page;
      logic [31:0] value;
      logic [15:0] ignore;
      logic        oneshot;
      logic [15:0] ident;
   } entry_type;

endpackage

// ===== design/breakpoint_match_table_top.sv =====
// Breakpoint match table top level: sequencer that scans, edits and compacts
// the entry memory. Depends on bmt_pkg and bmt_mem.
// Run, step, remove all, a refused add and a check that does not scan go from idle
// straight to done; an accepted add writes its entry in eval first. A scan reads
// and evaluates each entry visited; a removal moves each later entry up a slot.
// The next request can be accepted in the same cycle as the response is raised.
// Reset empties the table, sets the mode to inactive and the next id to one.
module breakpoint_match_table_top
   import bmt_pkg::*;
#(
   parameter int NUM_SLOTS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W = $clog2(NUM_SLOTS + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_EVAL = 3'd2;
   localparam logic [2:0] ST_SHFR = 3'd3;
   localparam logic [2:0] ST_SHFW = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0]       state_ff, state_in;
   req_type          req_ff, req_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [15:0]      next_id_ff, next_id_in;
   logic [1:0]       mode_ff, mode_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] shf_ff, shf_in;
   logic             found_ff, found_in;
   logic [1:0]       status_ff, status_in;
   logic             hit_ff, hit_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   entry_type        wr_data, rd_data, new_entry;
   logic             match, clr_match;
   logic [15:0]      id_inc;

   bmt_mem #(.NUM_SLOTS(NUM_SLOTS), .IDX_W(IDX_W)) u_mem (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      match = 1'b0;
      if (rd_data.btype == req_ff.access_type) begin
         if (req_ff.access_type == TYPE_TIME) begin
            match = (req_ff.cycle_count >= rd_data.value);
         end else if (!rd_data.paged) begin
            match = (rd_data.value == req_ff.value);
         end else begin
            match = (rd_data.page == req_ff.mapped_page) &&
                    (rd_data.value == (req_ff.value & OFFSET_MASK));
         end
      end
      clr_match = !rd_data.paged && (rd_data.btype inside {TYPE_EXEC, TYPE_READ, TYPE_WRITE})
                  && (rd_data.value == {16'd0, req_ff.value[15:0]});
      id_inc = next_id_ff + 16'd1;
      new_entry.btype   = req_ff.access_type;
      new_entry.paged   = req_ff.page_given;
      new_entry.page    = req_ff.page_number;
      new_entry.value   = (req_ff.access_type == TYPE_TIME) ? req_ff.value
                          : {16'd0, req_ff.value[15:0]};
      new_entry.ignore  = req_ff.ignore_count;
      new_entry.oneshot = req_ff.oneshot;
      new_entry.ident   = next_id_ff;
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      total_in     = total_ff;
      next_id_in   = next_id_ff;
      mode_in      = mode_ff;
      idx_in       = idx_ff;
      shf_in       = shf_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      hit_in       = hit_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[IDX_W-1:0];
      wr_data      = rd_data;
      rd_addr      = idx_ff[IDX_W-1:0];

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               idx_in    = '0;
               found_in  = 1'b0;
               status_in = STATUS_OK;
               hit_in    = 1'b0;
               state_in  = ST_DONE;
               case (req_data.kind)
                  KIND_CHECK: begin
                     if (mode_ff == MODE_HALTED) begin
                        hit_in = 1'b1;
                     end else if (mode_ff == MODE_ACTIVE && total_ff != '0) begin
                        state_in = ST_READ;
                     end
                  end
                  KIND_ADD: begin
                     if (total_ff == CNT_W'(NUM_SLOTS)) begin
                        status_in = STATUS_FULL;
                     end else begin
                        state_in = ST_EVAL;
                     end
                  end
                  KIND_REMOVE, KIND_IGNORE, KIND_CLEAR: begin
                     if (total_ff == '0) begin
                        status_in = STATUS_MISSING;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  KIND_ALL: begin
                     total_in   = '0;
                     next_id_in = 16'd1;
                     if (mode_ff == MODE_ACTIVE) begin
                        mode_in = MODE_INACTIVE;
                     end
                  end
                  KIND_RUN: begin
                     mode_in = (total_ff != '0) ? MODE_ACTIVE : MODE_INACTIVE;
                  end
                  default: begin
                     mode_in = MODE_HALTED;
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = ST_READ;
            case (req_ff.kind)
               KIND_ADD: begin
                  wr_en           = 1'b1;
                  wr_addr         = total_ff[IDX_W-1:0];
                  wr_data         = new_entry;
                  next_id_in      = (id_inc == 16'd0) ? 16'd1 : id_inc;
                  total_in        = total_ff + CNT_W'(1);
                  req_in.entry_id = next_id_ff;
                  if (mode_ff == MODE_INACTIVE) begin
                     mode_in = MODE_ACTIVE;
                  end
                  state_in = ST_DONE;
               end
               KIND_CHECK: begin
                  if (match && rd_data.ignore != 16'd0) begin
                     wr_en          = 1'b1;
                     wr_data.ignore = rd_data.ignore - 16'd1;
                  end
                  if (match && rd_data.ignore == 16'd0) begin
                     hit_in  = 1'b1;
                     mode_in = MODE_HALTED;
                     if (rd_data.oneshot) begin
                        shf_in   = idx_ff;
                        state_in = ST_SHFR;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end else if (idx_ff + CNT_W'(1) >= total_ff) begin
                     state_in = ST_DONE;
                  end else begin
                     idx_in = idx_ff + CNT_W'(1);
                  end
               end
               KIND_REMOVE, KIND_IGNORE: begin
                  if (rd_data.ident == req_ff.entry_id) begin
                     if (req_ff.kind == KIND_IGNORE) begin
                        wr_en          = 1'b1;
                        wr_data.ignore = req_ff.ignore_count;
                        state_in       = ST_DONE;
                     end else begin
                        found_in = 1'b1;
                        shf_in   = idx_ff;
                        state_in = ST_SHFR;
                     end
                  end else if (idx_ff + CNT_W'(1) >= total_ff) begin
                     status_in = STATUS_MISSING;
                     state_in  = ST_DONE;
                  end else begin
                     idx_in = idx_ff + CNT_W'(1);
                  end
               end
               default: begin
                  // Clear address: idx is the read pointer, shf the write pointer.
                  if (clr_match) begin
                     found_in = 1'b1;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = shf_ff[IDX_W-1:0];
                     shf_in  = shf_ff + CNT_W'(1);
                  end
                  if (idx_ff + CNT_W'(1) >= total_ff) begin
                     total_in = clr_match ? shf_ff : shf_ff + CNT_W'(1);
                     if (!found_ff && !clr_match) begin
                        status_in = STATUS_MISSING;
                     end else if (mode_ff == MODE_ACTIVE && total_in == '0) begin
                        mode_in = MODE_INACTIVE;
                     end
                     state_in = ST_DONE;
                  end else begin
                     idx_in = idx_ff + CNT_W'(1);
                  end
               end
            endcase
         end
         ST_SHFR: begin
            rd_addr = IDX_W'(shf_ff + CNT_W'(1));
            if (shf_ff + CNT_W'(1) >= total_ff) begin
               total_in = total_ff - CNT_W'(1);
               if (mode_ff == MODE_ACTIVE && total_in == '0) begin
                  mode_in = MODE_INACTIVE;
               end
               state_in = ST_DONE;
            end else begin
               state_in = ST_SHFW;
            end
         end
         ST_SHFW: begin
            wr_en    = 1'b1;
            wr_addr  = shf_ff[IDX_W-1:0];
            shf_in   = shf_ff + CNT_W'(1);
            state_in = ST_SHFR;
         end
         default: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_in.hit      = hit_ff;
               rsp_in.status   = status_ff;
               rsp_in.mode_now = mode_ff;
               rsp_in.new_id   = (req_ff.kind == KIND_ADD && status_ff == STATUS_OK)
                                 ? req_ff.entry_id : 16'd0;
               state_in = ST_IDLE;
            end
         end
      endcase

      if (state_ff == ST_IDLE && req_valid && req_data.kind == KIND_CLEAR) begin
         shf_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
         next_id_ff   <= 16'd1;
         mode_ff      <= MODE_INACTIVE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
         next_id_ff   <= next_id_in;
         mode_ff      <= mode_in;
      end
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
      idx_ff    <= idx_in;
      shf_ff    <= shf_in;
      found_ff  <= found_in;
      status_ff <= status_in;
      hit_ff    <= hit_in;
   end

endmodule

// ===== design/bmt_mem.sv =====
// Entry memory of the breakpoint match table: one write port, one
// registered read port. Depends on bmt_pkg.
module bmt_mem
   import bmt_pkg::*;
#(
   parameter int NUM_SLOTS = 16,
   parameter int IDX_W     = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type mem [NUM_SLOTS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/bmt_checker.sv =====
// Port-level checker for the breakpoint match table, bound to the top level.
// Depends on bmt_pkg.
module bmt_checker
   import bmt_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_mode_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.mode_now == MODE_INACTIVE || rsp_data.mode_now == MODE_ACTIVE
                     || rsp_data.mode_now == MODE_HALTED))
      else $error("bad mode code");

   a_hit_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit |-> rsp_data.mode_now == MODE_HALTED)
      else $error("hit without halt");

   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

endmodule

bind breakpoint_match_table_top bmt_checker u_bmt_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);

// ===== bench/breakpoint_match_table_top_tb.sv =====
// Testbench for breakpoint_match_table_top: directed and random requests checked
// against a behavioral model of the breakpoint table. Depends on bmt_pkg and the RTL.
`timescale 1ns / 1ps
module breakpoint_match_table_top_tb;
   import bmt_pkg::*;

   localparam int SLOTS = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int REQ_W = $bits(req_type);

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   entry_type   table_q[$];
   logic [15:0] ident_next;
   logic [1:0]  mode_model;
   rsp_type     pending_rsp[$];
   int          failures = 0;
   int          cycles = 0;
   bit          done = 1'b0;

   breakpoint_match_table_top #(.NUM_SLOTS(SLOTS)) uut (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   function automatic bit entry_hits(entry_type e, req_type r);
      if (e.btype != r.access_type) return 1'b0;
      if (e.btype == TYPE_TIME) return r.cycle_count >= e.value;
      if (!e.paged) return e.value == r.value;
      return e.page == r.mapped_page && e.value == (r.value & OFFSET_MASK);
   endfunction

   function automatic rsp_type table_apply(req_type r);
      rsp_type   o;
      entry_type e;
      int        pos;
      int        i;
      int        found;
      o = '0;
      pos = -1;
      found = 0;
      case (r.kind)
         KIND_CHECK: begin
            if (mode_model == MODE_HALTED) begin
               o.hit = 1'b1;
            end else if (mode_model == MODE_ACTIVE) begin
               for (i = 0; i < table_q.size(); i++) begin
                  if (!entry_hits(table_q[i], r)) continue;
                  if (table_q[i].ignore != 0) begin
                     table_q[i].ignore = table_q[i].ignore - 16'd1;
                     continue;
                  end
                  if (table_q[i].oneshot) table_q.delete(i);
                  mode_model = MODE_HALTED;
                  o.hit = 1'b1;
                  break;
               end
            end
         end
         KIND_ADD: begin
            if (table_q.size() >= SLOTS) begin
               o.status = STATUS_FULL;
            end else begin
               e.btype = r.access_type;
               e.paged = r.page_given;
               e.page = r.page_number;
               e.value = (r.access_type == TYPE_TIME) ? r.value : {16'h0, r.value[15:0]};
               e.ignore = r.ignore_count;
               e.oneshot = r.oneshot;
               e.ident = ident_next;
               table_q.push_back(e);
               o.new_id = ident_next;
               ident_next = ident_next + 16'd1;
               if (ident_next == 16'd0) ident_next = 16'd1;
               if (mode_model == MODE_INACTIVE) mode_model = MODE_ACTIVE;
            end
         end
         KIND_REMOVE, KIND_IGNORE: begin
            for (i = 0; i < table_q.size(); i++) begin
               if (table_q[i].ident == r.entry_id) begin
                  pos = i;
                  break;
               end
            end
            if (pos < 0) begin
               o.status = STATUS_MISSING;
            end else if (r.kind == KIND_IGNORE) begin
               table_q[pos].ignore = r.ignore_count;
            end else begin
               table_q.delete(pos);
               if (mode_model == MODE_ACTIVE && table_q.size() == 0)
                  mode_model = MODE_INACTIVE;
            end
         end
         KIND_CLEAR: begin
            i = 0;
            while (i < table_q.size()) begin
               if (!table_q[i].paged && table_q[i].btype inside {TYPE_EXEC, TYPE_READ,
                   TYPE_WRITE} && table_q[i].value == {16'h0, r.value[15:0]}) begin
                  table_q.delete(i);
                  found++;
               end else begin
                  i++;
               end
            end
            if (found == 0) o.status = STATUS_MISSING;
            else if (mode_model == MODE_ACTIVE && table_q.size() == 0)
               mode_model = MODE_INACTIVE;
         end
         KIND_ALL: begin
            table_q.delete();
            if (mode_model == MODE_ACTIVE) mode_model = MODE_INACTIVE;
            ident_next = 16'd1;
         end
         KIND_RUN: mode_model = (table_q.size() != 0) ? MODE_ACTIVE : MODE_INACTIVE;
         default: mode_model = MODE_HALTED;
      endcase
      o.mode_now = mode_model;
      return o;
   endfunction

   task automatic send_request(req_type r);
      int gap;
      gap = $urandom_range(0, 6);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_rsp.push_back(table_apply(r));
   endtask

   initial begin : rsp_side
      int hold;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         hold = $urandom_range(0, 6);
         if (hold != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT && !done) begin
         $display("RESULT: ERROR");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("response with no request outstanding");
            failures++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.hit !== want.hit) begin
               $error("hit expected %0d actual %0d", want.hit, rsp_data.hit);
               failures++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_data.status);
               failures++;
            end
            if (rsp_data.new_id !== want.new_id) begin
               $error("new_id expected %0d actual %0d", want.new_id, rsp_data.new_id);
               failures++;
            end
            if (rsp_data.mode_now !== want.mode_now) begin
               $error("mode_now expected %0d actual %0d", want.mode_now, rsp_data.mode_now);
               failures++;
            end
         end
      end
   end

   function automatic req_type random_fill();
      req_type r;
      r = req_type'(REQ_W'({$urandom, $urandom, $urandom, $urandom}));
      r.access_type = 3'($urandom_range(0, 7));
      return r;
   endfunction

   function automatic req_type make_add(logic [2:0] t, logic [31:0] v, bit pg,
                                        logic [7:0] pn, logic [15:0] ign, bit once);
      req_type r;
      r = random_fill();
      r.kind = KIND_ADD;
      r.access_type = t;
      r.value = v;
      r.page_given = pg;
      r.page_number = pn;
      r.ignore_count = ign;
      r.oneshot = once;
      return r;
   endfunction

   function automatic req_type make_check(logic [2:0] t, logic [31:0] v,
                                          logic [7:0] pg, logic [31:0] cyc);
      req_type r;
      r = random_fill();
      r.kind = KIND_CHECK;
      r.access_type = t;
      r.value = v;
      r.mapped_page = pg;
      r.cycle_count = cyc;
      return r;
   endfunction

   function automatic req_type make_simple(logic [2:0] k, logic [15:0] id,
                                           logic [15:0] ign);
      req_type r;
      r = random_fill();
      r.kind = k;
      r.entry_id = id;
      r.ignore_count = ign;
      return r;
   endfunction

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      send_request(make_check(TYPE_EXEC, 32'h0, 8'h0, 32'h0));
      send_request(make_simple(KIND_RUN, 16'h0, 16'h0));
      send_request(make_simple(KIND_REMOVE, 16'h5, 16'h0));
      send_request(make_add(TYPE_EXEC, 32'hffff_1234, 1'b0, 8'h0, 16'h1, 1'b0));
      send_request(make_add(TYPE_READ, 32'h0000_3fff, 1'b1, 8'hff, 16'h0, 1'b1));
      send_request(make_add(TYPE_TIME, 32'hffff_fff0, 1'b0, 8'h0, 16'h0, 1'b1));
      send_request(make_add(TYPE_RSVD7, 32'h0000_0042, 1'b0, 8'h0, 16'hffff, 1'b0));
      send_request(make_check(TYPE_EXEC, 32'h0000_1234, 8'h0, 32'h0));
      send_request(make_check(TYPE_EXEC, 32'h0000_1234, 8'h0, 32'h0));
      send_request(make_check(TYPE_EXEC, 32'h0000_1234, 8'h0, 32'h0));
      send_request(make_simple(KIND_RUN, 16'h0, 16'h0));
      send_request(make_check(TYPE_READ, 32'hffff_ffff, 8'hff, 32'h0));
      send_request(make_simple(KIND_RUN, 16'h0, 16'h0));
      send_request(make_check(TYPE_TIME, 32'h0, 8'h0, 32'hffff_ffff));
      send_request(make_simple(KIND_STEP, 16'h0, 16'h0));
      send_request(make_simple(KIND_RUN, 16'h0, 16'h0));
      send_request(make_simple(KIND_IGNORE, 16'h4, 16'h2));
      send_request(make_simple(KIND_IGNORE, 16'hffff, 16'h2));
      send_request(make_check(TYPE_RSVD7, 32'h42, 8'h0, 32'h0));
      send_request(make_simple(KIND_CLEAR, 16'h0, 16'h0));
      send_request(make_simple(KIND_REMOVE, 16'h1, 16'h0));
      send_request(make_simple(KIND_REMOVE, 16'h4, 16'h0));
      send_request(make_simple(KIND_ALL, 16'h0, 16'h0));
   endtask

   task automatic test_table_full();
      int i;
      for (i = 0; i < SLOTS + 2; i++)
         send_request(make_add(TYPE_WRITE, 32'h100 + i, 1'b0, 8'h0, 16'h0, 1'b0));
      send_request(make_check(TYPE_WRITE, 32'h105, 8'h0, 32'h0));
      wait_drained();
      send_request(make_simple(KIND_ALL, 16'h0, 16'h0));
   endtask

   task automatic test_id_wrap();
      int i;
      for (i = 0; i < 65540; i++) begin
         if (table_q.size() >= 4) send_request(make_simple(KIND_REMOVE,
            table_q[0].ident, 16'h0));
         else send_request(make_add(TYPE_EXEC, 32'h10, 1'b0, 8'h0, 16'h0, 1'b0));
         if (ident_next > 16'h10 && ident_next < 16'hfff0) break;
      end
   endtask

   task automatic test_random();
      req_type r;
      int      n;
      int      pick;
      for (n = 0; n < 950; n++) begin
         r = random_fill();
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            r.kind = KIND_ADD;
            r.access_type = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 1)) r.value = $urandom_range(0, 15);
            r.page_number = 8'($urandom_range(0, 3));
            r.ignore_count = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                             : 16'($urandom_range(0, 2));
         end else if (pick < 65) begin
            r.kind = KIND_CHECK;
            if ($urandom_range(0, 3) != 0) begin
               r.value = ($urandom_range(0, 1) ? 32'h0 : ($urandom_range(0, 255) << 14))
                         | $urandom_range(0, 15);
               r.mapped_page = 8'($urandom_range(0, 3));
            end
         end else if (pick < 85) begin
            r.kind = 3'($urandom_range(KIND_REMOVE, KIND_IGNORE));
            if (table_q.size() != 0 && $urandom_range(0, 3) != 0)
               r.entry_id = table_q[$urandom_range(0, table_q.size() - 1)].ident;
            if ($urandom_range(0, 1)) r.value = $urandom_range(0, 15);
            r.ignore_count = 16'($urandom_range(0, 3));
         end else if (pick < 95) begin
            r.kind = $urandom_range(0, 1) ? KIND_RUN : KIND_STEP;
         end else begin
            r.kind = 3'($urandom_range(KIND_CHECK, KIND_STEP));
         end
         send_request(r);
         if (n == 500) wait_drained();
      end
   endtask

   initial begin
      ident_next = 16'd1;
      mode_model = MODE_INACTIVE;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_table_full();
      test_id_wrap();
      test_random();
      wait_drained();
      repeat (100) @(negedge clock);
      done = 1'b1;
      if (failures == 0 && pending_rsp.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
